// ===== design/lapd_pkg.sv =====
`default_nettype none

package lapd_pkg;

  localparam int CNT_W  = 7;
  localparam int REQ_W  = 2;
  localparam int OCT_W  = 8;
  localparam int LEN_W  = 3;
  localparam int SAPI_W = 6;
  localparam int TEI_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_RX_HDR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TX_I   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_SAPI     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_TEI      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NETWORK_SIDE = 2'd2;

  // Control field codes
  localparam logic [OCT_W-1:0] CTRL_RR      = 8'h01;
  localparam logic [OCT_W-1:0] SABME_MASK   = 8'hef;
  localparam logic [OCT_W-1:0] SABME_CODE   = 8'h6f;
  localparam logic [OCT_W-1:0] UA_CODE      = 8'h63;
  localparam logic [OCT_W-1:0] PF_BIT_MASK  = 8'h10;
  localparam logic [OCT_W-1:0] SABME_P_CODE = 8'h7f;

  localparam logic [LEN_W-1:0] LEN_U_FRAME  = 3'd3;
  localparam logic [LEN_W-1:0] LEN_IS_FRAME = 3'd4;

  typedef struct packed {
    logic [OCT_W-1:0] octet0;
    logic [OCT_W-1:0] octet1;
    logic [OCT_W-1:0] octet2;
    logic [OCT_W-1:0] octet3;
    logic [LEN_W-1:0] length;
    logic             deliver_up;
  } hdr_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [OCT_W-1:0] addr0;
    logic [OCT_W-1:0] addr1;
    logic [OCT_W-1:0] ctrl0;
    logic [OCT_W-1:0] ctrl1;
  } req_t;

endpackage

`default_nettype wire

// ===== design/lapd_link_header_engine.sv =====
`default_nettype none

// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+----------------------------------------
// in_       | input     | in_valid / in_ready     | req_type, rx address and control octets
// out_      | output    | out_valid / out_ready   | hdr_octet0..3, hdr_length, deliver_up
// cfg_      | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data (always ready)
//
// One transaction per cycle sustained while out_ready stays high; a request is decoded
// from the input register into the result register, and out_valid rises if it emits.
// V(A)/V(S)/V(R) update as a request leaves the input register, so the next
// request in line always sees them current.
// in_ready drops only when both registers are full and out_ready is low.
// rst_n is synchronous, active low; it clears the counters, config and valids.

module lapd_link_header_engine (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request channel
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic [lapd_pkg::REQ_W-1:0]        in_req_type,
  input  wire logic [lapd_pkg::OCT_W-1:0]        in_rx_addr_octet0,
  input  wire logic [lapd_pkg::OCT_W-1:0]        in_rx_addr_octet1,
  input  wire logic [lapd_pkg::OCT_W-1:0]        in_rx_ctrl_octet0,
  input  wire logic [lapd_pkg::OCT_W-1:0]        in_rx_ctrl_octet1,
  // header channel
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic [lapd_pkg::OCT_W-1:0]        out_hdr_octet0,
  output      logic [lapd_pkg::OCT_W-1:0]        out_hdr_octet1,
  output      logic [lapd_pkg::OCT_W-1:0]        out_hdr_octet2,
  output      logic [lapd_pkg::OCT_W-1:0]        out_hdr_octet3,
  output      logic [lapd_pkg::LEN_W-1:0]        out_hdr_length,
  output      logic                              out_deliver_up,
  // configuration channel
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [lapd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lapd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lapd_pkg::*;

  // Configuration registers
  logic [SAPI_W-1:0] own_sapi_r;
  logic [TEI_W-1:0]  own_tei_r;
  logic              network_side_r;

  // Link counters: V(A), V(S), V(R)
  logic [CNT_W-1:0] ack_count_r, ack_count_nxt;
  logic [CNT_W-1:0] send_count_r, send_count_nxt;
  logic [CNT_W-1:0] recv_count_r, recv_count_nxt;

  // Input register
  logic req_valid_r;
  req_t req_r;

  // Result register
  logic out_valid_r, out_valid_nxt;
  hdr_t hdr_r, hdr_nxt;
  logic hdr_emit;

  logic advance;
  logic in_accept;

  // Received-header decode
  logic [SAPI_W-1:0] rx_sapi;
  logic              rx_cr;
  logic [TEI_W-1:0]  rx_tei;
  logic              rx_pbit;
  logic [CNT_W-1:0]  rx_nr;
  logic              nr_in_window;
  logic              is_i_frame;
  logic              is_rr;
  logic              is_sabme;
  logic [CNT_W-1:0]  recv_inc;
  logic [OCT_W-1:0]  rx_addr0;
  logic [OCT_W-1:0]  rx_addr1;

  assign cfg_ready = 1'b1;

  // Drain the input register whenever the result register is free or emptying.
  assign advance   = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !req_valid_r || advance;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_sapi_r     <= '0;
      own_tei_r      <= '0;
      network_side_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OWN_SAPI:     own_sapi_r     <= cfg_data[SAPI_W-1:0];
        CFG_OWN_TEI:      own_tei_r      <= cfg_data[TEI_W-1:0];
        CFG_NETWORK_SIDE: network_side_r <= cfg_data[0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Hold a request until the decode stage takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r.req_type <= in_req_type;
      req_r.addr0    <= in_rx_addr_octet0;
      req_r.addr1    <= in_rx_addr_octet1;
      req_r.ctrl0    <= in_rx_ctrl_octet0;
      req_r.ctrl1    <= in_rx_ctrl_octet1;
    end
  end

  assign rx_sapi  = req_r.addr0[OCT_W-1:2];
  assign rx_cr    = req_r.addr0[1];
  assign rx_tei   = req_r.addr1[OCT_W-1:1];
  assign rx_pbit  = req_r.ctrl1[0];
  assign rx_nr    = req_r.ctrl1[OCT_W-1:1];
  assign rx_addr0 = {rx_sapi, rx_cr, 1'b0};
  assign rx_addr1 = {rx_tei, 1'b1};

  // N(R) is taken only from I and S frames, inside V(A)..V(S) by plain compare.
  assign nr_in_window = (req_r.ctrl0[1:0] != 2'b11) &&
                        (rx_nr >= ack_count_r) && (rx_nr <= send_count_r);
  assign is_i_frame   = !req_r.ctrl0[0];
  assign is_rr        = (req_r.ctrl0 == CTRL_RR);
  assign is_sabme     = ((req_r.ctrl0 & SABME_MASK) == SABME_CODE);
  assign recv_inc     = recv_count_r + CNT_W'(1);

  always_comb begin
    ack_count_nxt  = ack_count_r;
    send_count_nxt = send_count_r;
    recv_count_nxt = recv_count_r;
    hdr_emit       = 1'b0;
    hdr_nxt        = '0;

    case (req_r.req_type)
      REQ_RX_HDR: begin
        if (nr_in_window) begin
          ack_count_nxt = rx_nr;
        end
        hdr_nxt.octet0 = rx_addr0;
        hdr_nxt.octet1 = rx_addr1;
        if (is_i_frame) begin
          // Acknowledge with RR carrying the bumped V(R); pass the frame up.
          recv_count_nxt     = recv_inc;
          hdr_emit           = 1'b1;
          hdr_nxt.octet2     = CTRL_RR;
          hdr_nxt.octet3     = {recv_inc, rx_pbit};
          hdr_nxt.length     = LEN_IS_FRAME;
          hdr_nxt.deliver_up = 1'b1;
        end else if (is_rr) begin
          // Only an RR command (C/R opposite our side) gets a reply.
          hdr_emit       = (rx_cr != network_side_r);
          hdr_nxt.octet2 = CTRL_RR;
          hdr_nxt.octet3 = {recv_count_r, rx_pbit};
          hdr_nxt.length = LEN_IS_FRAME;
        end else if (is_sabme) begin
          // Link reset: clear every counter, answer UA with F copied from P.
          ack_count_nxt  = '0;
          send_count_nxt = '0;
          recv_count_nxt = '0;
          hdr_emit       = 1'b1;
          hdr_nxt.octet2 = UA_CODE | (req_r.ctrl0 & PF_BIT_MASK);
          hdr_nxt.octet3 = '0;
          hdr_nxt.length = LEN_U_FRAME;
        end
      end
      REQ_TX_I: begin
        hdr_emit       = 1'b1;
        hdr_nxt.octet0 = {own_sapi_r, network_side_r, 1'b0};
        hdr_nxt.octet1 = {own_tei_r, 1'b1};
        hdr_nxt.octet2 = {send_count_r, 1'b0};
        hdr_nxt.octet3 = {recv_count_r, 1'b0};
        hdr_nxt.length = LEN_IS_FRAME;
        send_count_nxt = send_count_r + CNT_W'(1);
      end
      REQ_START: begin
        hdr_emit       = 1'b1;
        hdr_nxt.octet0 = {own_sapi_r, network_side_r, 1'b0};
        hdr_nxt.octet1 = {own_tei_r, 1'b1};
        hdr_nxt.octet2 = SABME_P_CODE;
        hdr_nxt.octet3 = '0;
        hdr_nxt.length = LEN_U_FRAME;
      end
      default: ;  // unused request code: drop it
    endcase
  end

  // Commit counters only when the request actually leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_count_r  <= '0;
      send_count_r <= '0;
      recv_count_r <= '0;
    end else if (advance) begin
      ack_count_r  <= ack_count_nxt;
      send_count_r <= send_count_nxt;
      recv_count_r <= recv_count_nxt;
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = hdr_emit;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hdr_emit) begin
      hdr_r <= hdr_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hdr_octet0 = hdr_r.octet0;
  assign out_hdr_octet1 = hdr_r.octet1;
  assign out_hdr_octet2 = hdr_r.octet2;
  assign out_hdr_octet3 = hdr_r.octet3;
  assign out_hdr_length = hdr_r.length;
  assign out_deliver_up = hdr_r.deliver_up;

`ifndef ASSERT_OFF
  // Backpressure only when both registers are full and the sink stalls.
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (req_valid_r && out_valid_r && !out_ready))
    else $error("in_ready low without a full pipeline stall");

  // A transmitted I frame bumps V(S) by exactly one.
  a_vs_bump: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && req_r.req_type == REQ_TX_I)
    |=> (send_count_r == $past(send_count_r) + CNT_W'(1)))
    else $error("V(S) not advanced after I frame transmit");

  // A received SABME clears every counter.
  a_sabme_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && req_r.req_type == REQ_RX_HDR && !is_i_frame && !is_rr && is_sabme)
    |=> (ack_count_r == '0 && send_count_r == '0 && recv_count_r == '0))
    else $error("counters not cleared by SABME");

  // Only the reply to an I frame is flagged for delivery, always with 4 octets.
  a_deliver_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_deliver_up) |-> (out_hdr_length == LEN_IS_FRAME
                                         && out_hdr_octet2 == CTRL_RR))
    else $error("deliver_up on a non-RR reply");
`endif

endmodule

`default_nettype wire
